// ===== rtl/jvc_pkg.sv =====
package jvc_pkg;

    // Input opcodes
    typedef enum logic [1:0] {
        OP_AXIS   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_TICK   = 2'd2
    } t_opcode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_SEL    = 3'd0,
        CFG_Y_SEL    = 3'd1,
        CFG_Z_SEL    = 3'd2,
        CFG_DEADZONE = 3'd3,
        CFG_GAIN     = 3'd4,
        CFG_MAX_X    = 3'd5,
        CFG_MAX_Z    = 3'd6,
        CFG_MAX_ROT  = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 17;

    // Register reset values
    localparam logic [7:0]  RST_X_SEL    = 8'd0;
    localparam logic [7:0]  RST_Y_SEL    = 8'd1;
    localparam logic [7:0]  RST_Z_SEL    = 8'd2;
    localparam logic [14:0] RST_DEADZONE = 15'd2000;
    localparam logic [16:0] RST_GAIN     = 17'd65536;
    localparam logic [11:0] RST_MAX_X    = 12'd300;
    localparam logic [11:0] RST_MAX_Z    = 12'd300;
    localparam logic [12:0] RST_MAX_ROT  = 13'd1000;

    // Change thresholds and deadband limits
    localparam logic signed [13:0] VEL_STEP = 14'sd8;
    localparam logic signed [14:0] ROT_STEP = 15'sd20;

    localparam logic [7:0] BUTTON_MAIN = 8'd0;

    // Axis event decode toward the state registers
    typedef struct packed {
        logic               wr_fwd;
        logic               wr_side;
        logic               wr_turn;
        logic signed [15:0] norm;
    } t_axis_upd;

    // Velocity scaling on a send tick
    typedef struct packed {
        logic               moved;
        logic signed [12:0] raw_x;
        logic signed [12:0] raw_z;
        logic signed [13:0] raw_rot;
        logic signed [12:0] db_x;
        logic signed [12:0] db_z;
        logic signed [13:0] db_rot;
    } t_tick_res;

endpackage

// ===== rtl/joystick_velocity_conditioner.sv =====
// Channel  | valid    | stall    | payload
// ---------+----------+----------+-------------------------------------
// input    | i_valid  | o_stall  | i_opcode, i_value, i_number
// output   | o_valid  | i_stall  | o_vel_x, o_vel_z, o_vel_rot
// config   | i_cfg_we | (none)   | i_cfg_index, i_cfg_data
//
// One beat per cycle while o_stall is low: a beat lands in the input register,
// and one combinational pass (one multiplier per axis) then writes the result
// register, which drives o_valid.
// Synchronous active-low reset clears state and restores register defaults.
// A send tick waits in the input register while a result is held by i_stall;
// other beats pass through regardless of the output side.
module joystick_velocity_conditioner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_index,
    input  logic [jvc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_opcode,
    input  logic signed [15:0]              i_value,
    input  logic [7:0]                      i_number,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [12:0]              o_vel_x,
    output logic signed [12:0]              o_vel_z,
    output logic signed [13:0]              o_vel_rot
);
    import jvc_pkg::*;

    // Configuration registers
    logic [7:0]  r_x_sel;
    logic [7:0]  r_y_sel;
    logic [7:0]  r_z_sel;
    logic [14:0] r_deadzone;
    logic [16:0] r_gain;
    logic [11:0] r_max_x;
    logic [11:0] r_max_z;
    logic [12:0] r_max_rot;

    // Input register
    logic               r_in_valid;
    logic [1:0]         r_op;
    logic signed [15:0] r_value;
    logic [7:0]         r_number;

    // Block state
    logic signed [15:0] r_fwd;
    logic signed [15:0] r_side;
    logic signed [15:0] r_turn;
    logic               r_held;
    logic               r_event_seen;
    logic               r_primed;
    logic signed [12:0] r_last_x;
    logic signed [12:0] r_last_z;
    logic signed [13:0] r_last_rot;

    // Output register
    logic               r_out_valid;
    logic signed [12:0] r_out_x;
    logic signed [12:0] r_out_z;
    logic signed [13:0] r_out_rot;

    logic      proc_go;
    logic      in_ready;
    logic      out_free;
    logic      send_cmd;
    t_axis_upd axis_upd;
    t_tick_res tick_res;

    // Flow control: only a tick needs the output slot
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        proc_go  = r_in_valid && ((r_op != OP_TICK) || out_free);
        in_ready = !r_in_valid || proc_go;
    end

    // A primed tick with enough change loads a new command
    always_comb begin
        send_cmd = proc_go && (r_op == OP_TICK) && r_event_seen && r_primed &&
                   tick_res.moved;
    end

    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;
    assign o_vel_x   = r_out_x;
    assign o_vel_z   = r_out_z;
    assign o_vel_rot = r_out_rot;

    jvc_axis_norm u_axis_norm (
        .i_value    (r_value),
        .i_number   (r_number),
        .i_x_sel    (r_x_sel),
        .i_y_sel    (r_y_sel),
        .i_z_sel    (r_z_sel),
        .i_deadzone (r_deadzone),
        .i_gain     (r_gain),
        .i_held     (r_held),
        .o_upd      (axis_upd)
    );

    jvc_vel_scale u_vel_scale (
        .i_fwd      (r_fwd),
        .i_side     (r_side),
        .i_turn     (r_turn),
        .i_max_x    (r_max_x),
        .i_max_z    (r_max_z),
        .i_max_rot  (r_max_rot),
        .i_last_x   (r_last_x),
        .i_last_z   (r_last_z),
        .i_last_rot (r_last_rot),
        .o_res      (tick_res)
    );

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_sel    <= RST_X_SEL;
            r_y_sel    <= RST_Y_SEL;
            r_z_sel    <= RST_Z_SEL;
            r_deadzone <= RST_DEADZONE;
            r_gain     <= RST_GAIN;
            r_max_x    <= RST_MAX_X;
            r_max_z    <= RST_MAX_Z;
            r_max_rot  <= RST_MAX_ROT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_SEL:    r_x_sel    <= i_cfg_data[7:0];
                CFG_Y_SEL:    r_y_sel    <= i_cfg_data[7:0];
                CFG_Z_SEL:    r_z_sel    <= i_cfg_data[7:0];
                CFG_DEADZONE: r_deadzone <= i_cfg_data[14:0];
                CFG_GAIN:     r_gain     <= i_cfg_data[16:0];
                CFG_MAX_X:    r_max_x    <= i_cfg_data[11:0];
                CFG_MAX_Z:    r_max_z    <= i_cfg_data[11:0];
                CFG_MAX_ROT:  r_max_rot  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
        if (in_ready && i_valid) begin
            r_op     <= i_opcode;
            r_value  <= i_value;
            r_number <= i_number;
        end
    end

    // State update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd        <= '0;
            r_side       <= '0;
            r_turn       <= '0;
            r_held       <= 1'b0;
            r_event_seen <= 1'b0;
            r_primed     <= 1'b0;
            r_last_x     <= '0;
            r_last_z     <= '0;
            r_last_rot   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (send_cmd) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go) begin
                case (r_op)
                    OP_AXIS: begin
                        if (axis_upd.wr_fwd) begin
                            r_fwd <= axis_upd.norm;
                        end
                        if (axis_upd.wr_side) begin
                            r_side <= axis_upd.norm;
                        end
                        if (axis_upd.wr_turn) begin
                            r_turn <= axis_upd.norm;
                        end
                        r_event_seen <= 1'b1;
                    end
                    OP_BUTTON: begin
                        if (r_number == BUTTON_MAIN) begin
                            r_held       <= (r_value == 16'sd1);
                            r_event_seen <= 1'b1;
                            if (r_value == 16'sd1) begin
                                r_turn <= r_fwd;
                                r_fwd  <= '0;
                            end else begin
                                r_fwd  <= r_turn;
                                r_turn <= '0;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (r_event_seen) begin
                            if (!r_primed) begin
                                r_primed   <= 1'b1;
                                r_last_x   <= tick_res.raw_x;
                                r_last_z   <= tick_res.raw_z;
                                r_last_rot <= tick_res.raw_rot;
                            end else if (tick_res.moved) begin
                                r_last_x    <= tick_res.db_x;
                                r_last_z    <= tick_res.db_z;
                                r_last_rot  <= tick_res.db_rot;
                                r_out_x     <= tick_res.db_x;
                                r_out_z     <= tick_res.db_z;
                                r_out_rot   <= tick_res.db_rot;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Priming never happens without an event
    a_primed_after_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |-> r_event_seen)
        else $error("primed set without any event");

    // A result is only sent once primed
    a_out_needs_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_primed)
        else $error("result sent before priming");

    // The pending result is the last sent velocity set
    a_out_matches_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_vel_x == r_last_x && o_vel_z == r_last_z &&
                     o_vel_rot == r_last_rot))
        else $error("pending result differs from last sent values");

    // With button 0 held the forward axis stays cleared
    a_held_clears_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_fwd == 16'sd0))
        else $error("forward axis nonzero while button held");

endmodule

// ===== rtl/jvc_axis_norm.sv =====
module jvc_axis_norm (
    input  logic signed [15:0] i_value,
    input  logic [7:0]         i_number,
    input  logic [7:0]         i_x_sel,
    input  logic [7:0]         i_y_sel,
    input  logic [7:0]         i_z_sel,
    input  logic [14:0]        i_deadzone,
    input  logic [16:0]        i_gain,
    input  logic               i_held,
    output jvc_pkg::t_axis_upd o_upd
);
    import jvc_pkg::*;

    logic signed [16:0] v_ext;
    logic [16:0]        v_mag;
    logic signed [16:0] v_dz;
    logic signed [16:0] operand;
    logic signed [34:0] prod;
    logic signed [18:0] shifted;
    logic               hit_fwd;
    logic               hit_side;
    logic               hit_turn;

    // Deadzone on raw magnitude
    always_comb begin
        v_ext = {i_value[15], i_value};
        v_mag = v_ext[16] ? 17'(-v_ext) : 17'(v_ext);
        v_dz  = (v_mag < {2'b00, i_deadzone}) ? 17'sd0 : v_ext;
    end

    // Axis routing: forward wins, then sideways, then turn
    always_comb begin
        hit_fwd  = (i_number == i_x_sel) && !i_held;
        hit_side = !hit_fwd && (i_number == i_y_sel);
        hit_turn = !hit_fwd && !hit_side &&
                   ((i_number == i_z_sel) || ((i_number == i_x_sel) && i_held));
    end

    // Scale to Q1.15 with floor and saturation; sideways is negated
    always_comb begin
        operand = hit_side ? 17'(-v_dz) : v_dz;
        prod    = operand * $signed({1'b0, i_gain});
        shifted = prod[34:16];
        if (shifted > 19'sd32767) begin
            o_upd.norm = 16'sh7FFF;
        end else if (shifted < -19'sd32768) begin
            o_upd.norm = 16'sh8000;
        end else begin
            o_upd.norm = shifted[15:0];
        end
        o_upd.wr_fwd  = hit_fwd;
        o_upd.wr_side = hit_side;
        o_upd.wr_turn = hit_turn;
    end

endmodule

// ===== rtl/jvc_vel_scale.sv =====
module jvc_vel_scale (
    input  logic signed [15:0] i_fwd,
    input  logic signed [15:0] i_side,
    input  logic signed [15:0] i_turn,
    input  logic [11:0]        i_max_x,
    input  logic [11:0]        i_max_z,
    input  logic [12:0]        i_max_rot,
    input  logic signed [12:0] i_last_x,
    input  logic signed [12:0] i_last_z,
    input  logic signed [13:0] i_last_rot,
    output jvc_pkg::t_tick_res o_res
);
    import jvc_pkg::*;

    logic signed [28:0] px;
    logic signed [28:0] pz;
    logic signed [29:0] pr;
    logic signed [12:0] raw_x;
    logic signed [12:0] raw_z;
    logic signed [13:0] raw_rot;
    logic               moved;
    logic signed [12:0] db_x;
    logic signed [12:0] db_z;
    logic signed [13:0] db_rot;
    logic signed [13:0] dx;
    logic signed [13:0] dz;
    logic signed [14:0] dr;
    logic signed [13:0] vx_ext;
    logic signed [13:0] vz_ext;
    logic signed [14:0] vr_ext;

    // Axis times full-scale speed, floor shift by 15
    always_comb begin
        px = i_fwd  * $signed({1'b0, i_max_x});
        pz = i_side * $signed({1'b0, i_max_z});
        pr = i_turn * $signed({1'b0, i_max_rot});
        raw_x   = px[27:15];
        raw_z   = pz[27:15];
        raw_rot = pr[28:15];
    end

    // Change detect against last sent values
    always_comb begin
        dx = {raw_x[12], raw_x} - {i_last_x[12], i_last_x};
        dz = {raw_z[12], raw_z} - {i_last_z[12], i_last_z};
        dr = {raw_rot[13], raw_rot} - {i_last_rot[13], i_last_rot};
        moved = !((dx > -VEL_STEP) && (dx < VEL_STEP)) ||
                !((dz > -VEL_STEP) && (dz < VEL_STEP)) ||
                !((dr > -ROT_STEP) && (dr < ROT_STEP));
    end

    // Deadband small velocities to zero
    always_comb begin
        vx_ext = {raw_x[12], raw_x};
        vz_ext = {raw_z[12], raw_z};
        vr_ext = {raw_rot[13], raw_rot};
        db_x   = ((vx_ext > -VEL_STEP) && (vx_ext < VEL_STEP)) ? 13'sd0 : raw_x;
        db_z   = ((vz_ext > -VEL_STEP) && (vz_ext < VEL_STEP)) ? 13'sd0 : raw_z;
        db_rot = ((vr_ext > -ROT_STEP) && (vr_ext < ROT_STEP)) ? 14'sd0 : raw_rot;
    end

    assign o_res = '{moved: moved, raw_x: raw_x, raw_z: raw_z, raw_rot: raw_rot,
                     db_x: db_x, db_z: db_z, db_rot: db_rot};

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jvc_pkg::*;

    // Opcode value the block has no use for
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int DRAIN_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] z;
        logic signed [13:0] rot;
    } t_vel;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_VEL
    } t_row_check;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct {
        logic [1:0] op;
        int         raw;
        int         num;
        t_row_check chk;
        int         vx;
        int         vz;
        int         vr;
    } t_dir_row;

    // Directed rows, run with the reset register values
    t_dir_row dir_tab [25] = '{
        '{OP_TICK,        0, 0, CHK_NONE,     0,    0,     0}, // tick before any event
        '{OP_UNUSED,   1234, 0, CHK_NONE,     0,    0,     0}, // unknown opcode
        '{OP_TICK,        0, 0, CHK_NONE,     0,    0,     0}, // still nothing seen
        '{OP_BUTTON,      1, 5, CHK_NONE,     0,    0,     0}, // button other than 0
        '{OP_TICK,        0, 0, CHK_NONE,     0,    0,     0},
        '{OP_AXIS,    12345, 7, CHK_MODEL,    0,    0,     0}, // axis with no selector
        '{OP_TICK,        0, 0, CHK_NONE,     0,    0,     0}, // priming tick
        '{OP_AXIS,    32767, 0, CHK_MODEL,    0,    0,     0},
        '{OP_TICK,        0, 0, CHK_VEL,    299,    0,     0},
        '{OP_TICK,        0, 0, CHK_NONE,     0,    0,     0}, // nothing moved
        '{OP_AXIS,   -32768, 1, CHK_MODEL,    0,    0,     0}, // negated, saturates
        '{OP_TICK,        0, 0, CHK_VEL,    299,  299,     0},
        '{OP_AXIS,   -32768, 2, CHK_MODEL,    0,    0,     0},
        '{OP_TICK,        0, 0, CHK_VEL,    299,  299, -1000},
        '{OP_AXIS,     1999, 0, CHK_MODEL,    0,    0,     0}, // inside deadzone
        '{OP_AXIS,    -2000, 1, CHK_MODEL,    0,    0,     0}, // deadzone edge
        '{OP_TICK,        0, 0, CHK_VEL,      0,   18, -1000},
        '{OP_BUTTON,      1, 0, CHK_MODEL,    0,    0,     0}, // press: forward to turn
        '{OP_AXIS,    16384, 0, CHK_MODEL,    0,    0,     0}, // x drives turn while held
        '{OP_TICK,        0, 0, CHK_VEL,      0,   18,   500},
        '{OP_BUTTON,      2, 0, CHK_MODEL,    0,    0,     0}, // level 2 reads released
        '{OP_TICK,        0, 0, CHK_VEL,    150,   18,     0},
        '{OP_AXIS,   -32768, 0, CHK_MODEL,    0,    0,     0},
        '{OP_AXIS,    32767, 1, CHK_MODEL,    0,    0,     0},
        '{OP_TICK,        0, 0, CHK_VEL,   -300, -300,     0}
    };

    // Register values per phase: x, y, z select, deadzone, gain, max x, max z, max rot
    localparam int unsigned REG_MAX [8] = '{255, 255, 255, 32767, 131071, 4095, 4095, 8191};
    int unsigned cfg_plan [NUM_PHASES][8] = '{
        '{  0,   1,   2,  2000,  65536,  300,  300, 1000},
        '{  3,   4,   5,     0, 131071, 4095, 4095, 8191},
        '{255, 255, 255, 32767,  65536,  300,  300, 1000}, // all selectors equal
        '{  0,   1,   2,     0,      0,    0,    0,    0},
        '{  7,   7,   9,    16,   4096, 4095,  100, 8191},
        '{  0,   0,   0,     0,      0,    0,    0,    0}, // filled at random
        '{  0,   0,   0,     0,      0,    0,    0,    0}, // random, z equals x
        '{  0,   1,   2,   100,  70000, 1000, 2000, 5000}
    };

    localparam logic signed [15:0] RAW_EDGES [6] = '{
        16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh0000, 16'sh0001, 16'shFFFF
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [2:0]             i_cfg_index = 3'd0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic [1:0]             i_opcode    = 2'd0;
    logic signed [15:0]     i_value     = '0;
    logic [7:0]             i_number    = '0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic signed [12:0]     o_vel_x;
    logic signed [12:0]     o_vel_z;
    logic signed [13:0]     o_vel_rot;

    int unsigned send_pct  = 0;
    int unsigned stall_pct = 0;
    int          mismatches = 0;

    t_vel cmds_due [$];

    // Shadow of the block: registers
    logic [7:0]  sel_x     = RST_X_SEL;
    logic [7:0]  sel_y     = RST_Y_SEL;
    logic [7:0]  sel_z     = RST_Z_SEL;
    logic [14:0] dead_zone = RST_DEADZONE;
    logic [16:0] gain      = RST_GAIN;
    logic [11:0] top_x     = RST_MAX_X;
    logic [11:0] top_z     = RST_MAX_Z;
    logic [12:0] top_rot   = RST_MAX_ROT;

    // Shadow of the block: state
    logic signed [15:0] axis_fwd    = '0;
    logic signed [15:0] axis_side   = '0;
    logic signed [15:0] axis_turn   = '0;
    logic               button_held = 1'b0;
    logic               event_seen  = 1'b0;
    logic               primed      = 1'b0;
    logic signed [12:0] last_x      = '0;
    logic signed [12:0] last_z      = '0;
    logic signed [13:0] last_rot    = '0;

    joystick_velocity_conditioner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_value     (i_value),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_vel_x     (o_vel_x),
        .o_vel_z     (o_vel_z),
        .o_vel_rot   (o_vel_rot)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint mag(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    // Raw position to Q1.15, floored and saturated
    function automatic logic signed [15:0] to_q15(input longint raw);
        longint p;
        p = (raw * longint'(gain)) >>> 16;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return 16'(p);
    endfunction

    function automatic longint scale_vel(input logic signed [15:0] a, input longint top);
        return (longint'(a) * top) >>> 15;
    endfunction

    // Advances the shadow state by one beat; returns 1 when a command is due
    function automatic bit next_velocity_cmd(input logic [1:0] op,
                                             input logic signed [15:0] raw,
                                             input logic [7:0] num, output t_vel cmd);
        longint v;
        longint xv;
        longint zv;
        longint rv;
        cmd = '0;
        v = longint'(raw);
        case (op)
            OP_AXIS: begin
                if (mag(v) < longint'(dead_zone)) v = 0;
                // forward beats sideways beats turn; x lands on turn while held
                if (num == sel_x && !button_held) axis_fwd = to_q15(v);
                else if (num == sel_y) axis_side = to_q15(-v);
                else if (num == sel_z || num == sel_x) axis_turn = to_q15(v);
                event_seen = 1'b1;
                return 1'b0;
            end
            OP_BUTTON: begin
                if (num == BUTTON_MAIN) begin
                    button_held = (raw == 16'sd1);
                    if (button_held) begin
                        axis_turn = axis_fwd;
                        axis_fwd  = '0;
                    end else begin
                        axis_fwd  = axis_turn;
                        axis_turn = '0;
                    end
                    event_seen = 1'b1;
                end
                return 1'b0;
            end
            OP_TICK: begin
                if (!event_seen) return 1'b0;
                xv = scale_vel(axis_fwd, longint'(top_x));
                zv = scale_vel(axis_side, longint'(top_z));
                rv = scale_vel(axis_turn, longint'(top_rot));
                // first tick after the first event only loads the last-sent values
                if (!primed) begin
                    primed   = 1'b1;
                    last_x   = 13'(xv);
                    last_z   = 13'(zv);
                    last_rot = 14'(rv);
                    return 1'b0;
                end
                if (mag(xv - longint'(last_x)) < longint'(VEL_STEP) &&
                    mag(zv - longint'(last_z)) < longint'(VEL_STEP) &&
                    mag(rv - longint'(last_rot)) < longint'(ROT_STEP))
                    return 1'b0;
                // deadband small velocities before sending
                if (mag(xv) < longint'(VEL_STEP)) xv = 0;
                if (mag(zv) < longint'(VEL_STEP)) zv = 0;
                if (mag(rv) < longint'(ROT_STEP)) rv = 0;
                last_x   = 13'(xv);
                last_z   = 13'(zv);
                last_rot = 14'(rv);
                cmd.x    = last_x;
                cmd.z    = last_z;
                cmd.rot  = last_rot;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_X_SEL:    sel_x     = data[7:0];
            CFG_Y_SEL:    sel_y     = data[7:0];
            CFG_Z_SEL:    sel_z     = data[7:0];
            CFG_DEADZONE: dead_zone = data[14:0];
            CFG_GAIN:     gain      = data[16:0];
            CFG_MAX_X:    top_x     = data[11:0];
            CFG_MAX_Z:    top_z     = data[11:0];
            CFG_MAX_ROT:  top_rot   = data[12:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drive one beat, wait for it to be taken, then queue what it should produce
    task automatic send_beat(input logic [1:0] op, input logic signed [15:0] raw,
                             input logic [7:0] num, input t_row_check chk,
                             input t_vel typed);
        int   gap;
        t_vel cmd;
        bit   due;
        gap = 0;
        if (send_pct != 0)
            while ($urandom_range(99) < send_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= raw;
        i_number <= num;
        do @(posedge i_clk); while (o_stall);
        due = next_velocity_cmd(op, raw, num, cmd);
        case (chk)
            CHK_MODEL: if (due) cmds_due.push_back(cmd);
            CHK_VEL:   cmds_due.push_back(typed);
            default: ;
        endcase
    endtask

    // Hold off the sender until every command has come and the pipe is empty
    task automatic drain_pipe();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (cmds_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (cmds_due.size() != 0) begin
            $display("%0t missing velocity commands: expected %0d more, got none",
                     $time, cmds_due.size());
            mismatches++;
            cmds_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver stall
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Compare each command beat with the oldest one due
    always @(posedge i_clk) begin
        t_vel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (cmds_due.size() == 0) begin
                $display("%0t unexpected command: expected none, got x=%0d z=%0d rot=%0d",
                         $time, o_vel_x, o_vel_z, o_vel_rot);
                mismatches++;
            end else begin
                want = cmds_due.pop_front();
                if (o_vel_x !== want.x) begin
                    $display("%0t vel_x: expected %0d, got %0d", $time, want.x, o_vel_x);
                    mismatches++;
                end
                if (o_vel_z !== want.z) begin
                    $display("%0t vel_z: expected %0d, got %0d", $time, want.z, o_vel_z);
                    mismatches++;
                end
                if (o_vel_rot !== want.rot) begin
                    $display("%0t vel_rot: expected %0d, got %0d",
                             $time, want.rot, o_vel_rot);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_vel              typed;
        t_idle_mode        mode;
        int unsigned       pick;
        logic signed [15:0] raw;
        logic [7:0]        num;
        longint            m;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        foreach (dir_tab[i]) begin
            typed.x   = 13'(dir_tab[i].vx);
            typed.z   = 13'(dir_tab[i].vz);
            typed.rot = 14'(dir_tab[i].vr);
            send_beat(dir_tab[i].op, 16'(dir_tab[i].raw), 8'(dir_tab[i].num),
                      dir_tab[i].chk, typed);
        end

        // Random phases, each with its own register set and idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipe();
            if (p == 5 || p == 6)
                for (int k = 0; k < 8; k++) cfg_plan[p][k] = $urandom_range(REG_MAX[k]);
            if (p == 6) cfg_plan[p][2] = cfg_plan[p][0];
            for (int k = 0; k < 8; k++)
                write_reg(t_cfg_idx'(k), CFG_DATA_W'(cfg_plan[p][k]));

            mode = t_idle_mode'(p % 4);
            case (mode)
                IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
                IDLE_SEND: begin send_pct = 84; stall_pct = 0;  end
                IDLE_RECV: begin send_pct = 0;  stall_pct = 84; end
                default:   begin send_pct = 17; stall_pct = 17; end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    // axis position: full range, edges, around the deadzone, tiny, mid range
                    case ($urandom_range(5))
                        0, 1: raw = 16'($urandom);
                        2:    raw = RAW_EDGES[$urandom_range(5)];
                        3: begin
                            m = longint'(dead_zone) + longint'($urandom_range(6)) - 3;
                            if (m > 32767) m = 32767;
                            if (m < 0) m = 0;
                            raw = 16'(m);
                            if ($urandom_range(1) == 1) raw = -raw;
                        end
                        4:    raw = 16'($urandom_range(255)) - 16'sd128;
                        default: raw = 16'($urandom_range(32767)) - 16'sd16384;
                    endcase
                    case ($urandom_range(9))
                        0, 1, 2: num = sel_x;
                        3, 4, 5: num = sel_y;
                        6, 7:    num = sel_z;
                        default: num = 8'($urandom_range(255));
                    endcase
                    send_beat(OP_AXIS, raw, num, CHK_MODEL, '0);
                end else if (pick < 55) begin
                    num = ($urandom_range(9) < 8) ? BUTTON_MAIN : 8'($urandom_range(255));
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: raw = 16'sd1;
                        5, 6, 7:       raw = 16'sd0;
                        default:       raw = 16'($urandom);
                    endcase
                    send_beat(OP_BUTTON, raw, num, CHK_MODEL, '0);
                end else if (pick < 95) begin
                    send_beat(OP_TICK, 16'($urandom), 8'($urandom_range(255)), CHK_MODEL, '0);
                end else begin
                    send_beat(OP_UNUSED, 16'($urandom), 8'($urandom_range(255)),
                              CHK_MODEL, '0);
                end
            end
        end

        drain_pipe();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
